FILE: rtl/serial_rx_fifo_with_interrupt_top_macros.svh
// assertion macros for the serial receive fifo block
// used by the datapath module; needs clock and reset in scope
`ifndef SERIAL_RX_FIFO_WITH_INTERRUPT_TOP_MACROS_SVH
`define SERIAL_RX_FIFO_WITH_INTERRUPT_TOP_MACROS_SVH

// same-cycle implication, checked on every rising clock edge out of reset
`define SRXFI_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("srxfi same-cycle check failed");

// next-cycle implication, checked on every rising clock edge out of reset
`define SRXFI_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("srxfi next-cycle check failed");

`endif

FILE: rtl/srxfi_pkg.sv
// shared types and constants for the serial receive fifo block
// no dependencies
`default_nettype none

package srxfi_pkg;

   // fifo geometry
   localparam int FIFO_DEPTH = 16;
   localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

   // bus ports
   localparam logic [31:0] STATUS_PORT = 32'd110;
   localparam logic [31:0] DATA_PORT   = 32'd111;

   // status register bits
   localparam int ST_READY_BIT     = 0;
   localparam int ST_TX_READY_BIT  = 1;
   localparam int ST_INTERRUPT_BIT = 2;

   // word function codes
   typedef enum logic [1:0] {
      FN_RECEIVE = 2'd0,
      FN_READ    = 2'd1,
      FN_WRITE   = 2'd2,
      FN_TICK    = 2'd3
   } func_type;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EXEC = 3'b010,
      ST_RESP = 3'b100
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;   // capture the incoming word
      logic exec;   // apply the word to the state, form the result
   } cmd_type;

endpackage

`default_nettype wire

FILE: rtl/srxfi_ctrl.sv
// controller state machine for the serial receive fifo block
// depends on srxfi_pkg
`default_nettype none

module srxfi_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output srxfi_pkg::cmd_type    cmd
);
   import srxfi_pkg::*;

   state_type state_ff;
   state_type state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // handshakes and datapath commands
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);
   assign cmd.load  = (state_ff == ST_IDLE) && req_valid;
   assign cmd.exec  = (state_ff == ST_EXEC);

endmodule

`default_nettype wire

FILE: rtl/srxfi_dp.sv
// datapath for the serial receive fifo block: fifo store, pointers, flags
// depends on srxfi_pkg and serial_rx_fifo_with_interrupt_top_macros.svh
`default_nettype none

module srxfi_dp (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire srxfi_pkg::cmd_type cmd,
   input  wire logic [1:0]         req_func,
   input  wire logic [31:0]        req_port,
   input  wire logic [7:0]         req_wdata,
   input  wire logic [7:0]         req_rx_byte,
   input  wire logic               req_cpu_int_enable,
   output logic [7:0]              rsp_rdata,
   output logic                    rsp_tx_valid,
   output logic [7:0]              rsp_tx_byte,
   output logic                    rsp_irq
);
   import srxfi_pkg::*;

   // captured word
   func_type    func_ff;
   logic [31:0] port_ff;
   logic [7:0]  wdata_ff;
   logic [7:0]  rx_byte_ff;
   logic        cpu_ie_ff;

   // fifo state
   logic [7:0]       mem [FIFO_DEPTH];
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rx_en_ff, rx_en_in;
   logic             pending_ff, pending_in;
   logic             delivery_ff, delivery_in;

   // result registers
   logic [7:0] rdata_ff, rdata_in;
   logic       sel_mem_ff, sel_mem_in;
   logic [7:0] mem_q_ff;
   logic       tx_valid_ff, tx_valid_in;
   logic [7:0] tx_byte_ff, tx_byte_in;
   logic       irq_ff, irq_in;

   logic is_status, is_data, not_empty, full, do_push, do_pop;
   logic [PTR_W-1:0] head_inc, tail_inc;

   // capture the word on accept
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff    <= func_type'(req_func);
         port_ff    <= req_port;
         wdata_ff   <= req_wdata;
         rx_byte_ff <= req_rx_byte;
         cpu_ie_ff  <= req_cpu_int_enable;
      end
   end

   // decode
   assign is_status = (port_ff == STATUS_PORT);
   assign is_data   = (port_ff == DATA_PORT);
   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == CNT_W'(FIFO_DEPTH));
   assign do_push   = cmd.exec && (func_ff == FN_RECEIVE) && !full;
   assign do_pop    = cmd.exec && (func_ff == FN_READ) && is_data && not_empty;
   assign head_inc  = (head_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign tail_inc  = (tail_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : tail_ff + 1'b1;

   // state update and result for the captured word
   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      count_in    = count_ff;
      rx_en_in    = rx_en_ff;
      pending_in  = pending_ff;
      delivery_in = delivery_ff;
      rdata_in    = rdata_ff;
      sel_mem_in  = sel_mem_ff;
      tx_valid_in = tx_valid_ff;
      tx_byte_in  = tx_byte_ff;
      irq_in      = irq_ff;
      if (cmd.exec) begin
         rdata_in    = '0;
         sel_mem_in  = 1'b0;
         tx_valid_in = 1'b0;
         tx_byte_in  = '0;
         irq_in      = 1'b0;
         unique case (func_ff)
            FN_RECEIVE: begin
               if (!full) begin
                  tail_in  = tail_inc;
                  count_in = count_ff + 1'b1;
               end
               // fifo is never empty after a receive
               if (rx_en_ff && !pending_ff) begin
                  pending_in  = 1'b1;
                  delivery_in = 1'b1;
               end
            end
            FN_READ: begin
               if (is_status) begin
                  rdata_in[ST_READY_BIT]     = not_empty;
                  rdata_in[ST_TX_READY_BIT]  = 1'b1;
                  rdata_in[ST_INTERRUPT_BIT] = pending_ff;
                  pending_in                 = 1'b0;
               end else if (is_data && not_empty) begin
                  sel_mem_in = 1'b1;
                  head_in    = head_inc;
                  count_in   = count_ff - 1'b1;
               end
            end
            FN_WRITE: begin
               if (is_status) begin
                  rx_en_in = wdata_ff[0];
                  if (!rx_en_ff && wdata_ff[0] && not_empty && !pending_ff) begin
                     pending_in  = 1'b1;
                     delivery_in = 1'b1;
                  end
               end else if (is_data) begin
                  tx_valid_in = 1'b1;
                  tx_byte_in  = wdata_ff;
               end
            end
            FN_TICK: begin
               if (delivery_ff && cpu_ie_ff) begin
                  delivery_in = 1'b0;
                  irq_in      = 1'b1;
               end
            end
            default: begin
               irq_in = 1'b0;
            end
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= '0;
         tail_ff     <= '0;
         count_ff    <= '0;
         rx_en_ff    <= 1'b0;
         pending_ff  <= 1'b0;
         delivery_ff <= 1'b0;
      end else begin
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         count_ff    <= count_in;
         rx_en_ff    <= rx_en_in;
         pending_ff  <= pending_in;
         delivery_ff <= delivery_in;
      end
   end

   // result registers
   always_ff @(posedge clock) begin
      rdata_ff    <= rdata_in;
      sel_mem_ff  <= sel_mem_in;
      tx_valid_ff <= tx_valid_in;
      tx_byte_ff  <= tx_byte_in;
      irq_ff      <= irq_in;
   end

   // fifo store: write at tail, registered read at head
   always_ff @(posedge clock) begin
      if (do_push) mem[tail_ff] <= rx_byte_ff;
      if (do_pop)  mem_q_ff     <= mem[head_ff];
   end

   assign rsp_rdata    = sel_mem_ff ? mem_q_ff : rdata_ff;
   assign rsp_tx_valid = tx_valid_ff;
   assign rsp_tx_byte  = tx_byte_ff;
   assign rsp_irq      = irq_ff;

   // checks
   `include "serial_rx_fifo_with_interrupt_top_macros.svh"

   `SRXFI_ASSERT_NOW(a_ptr_match, head_ff == tail_ff, count_ff == '0 || count_ff == CNT_W'(FIFO_DEPTH))
   `SRXFI_ASSERT_NOW(a_count_max, 1'b1, count_ff <= CNT_W'(FIFO_DEPTH))
   `SRXFI_ASSERT_NOW(a_delivery_raise, $rose(delivery_ff), $rose(pending_ff))
   `SRXFI_ASSERT_NOW(a_irq_consumes, $rose(irq_ff), $fell(delivery_ff))
   `SRXFI_ASSERT_NEXT(a_pop_nonempty, do_pop, count_ff == $past(count_ff) - 1'b1)

endmodule

`default_nettype wire

FILE: rtl/serial_rx_fifo_with_interrupt_top.sv
// top level of the serial receive fifo with interrupt
// depends on srxfi_pkg, srxfi_ctrl, srxfi_dp
//
//   channel | direction | handshake            | payload
//   req_    | in        | req_valid/req_stall  | func, port, wdata, rx_byte, cpu_int_enable
//   rsp_    | out       | rsp_valid/rsp_stall  | rdata, tx_valid, tx_byte, irq
//
// each word passes through three steps: capture, execute, present the result
// one word is in flight at a time; the controller state machine sets the pace
// the result register holds while rsp_stall is high, and req_stall stays high until it is taken
// reset is synchronous and active high and clears pointers, count and interrupt flags
`default_nettype none

module serial_rx_fifo_with_interrupt_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_func,
   input  wire logic [31:0] req_port,
   input  wire logic [7:0]  req_wdata,
   input  wire logic [7:0]  req_rx_byte,
   input  wire logic        req_cpu_int_enable,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_rdata,
   output logic             rsp_tx_valid,
   output logic [7:0]       rsp_tx_byte,
   output logic             rsp_irq
);
   import srxfi_pkg::*;

   cmd_type cmd;

   // sequencing
   srxfi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // fifo and flags
   srxfi_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_func           (req_func),
      .req_port           (req_port),
      .req_wdata          (req_wdata),
      .req_rx_byte        (req_rx_byte),
      .req_cpu_int_enable (req_cpu_int_enable),
      .rsp_rdata          (rsp_rdata),
      .rsp_tx_valid       (rsp_tx_valid),
      .rsp_tx_byte        (rsp_tx_byte),
      .rsp_irq            (rsp_irq)
   );

endmodule

`default_nettype wire
